/* hdl/jvm_bytecode_instruction_parser_macros.svh */
// Assertion macros shared by the bytecode parser modules.
// Each file that checks its own logic includes this header; it needs no other file.
`ifndef JVM_BYTECODE_INSTRUCTION_PARSER_MACROS_SVH
`define JVM_BYTECODE_INSTRUCTION_PARSER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define JBP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jbp assertion failed");

// Next-cycle implication, checked out of reset.
`define JBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jbp assertion failed");

`endif

/* hdl/jbp_pkg.sv */
// Shared types, codes and opcode classification for the bytecode parser.
// No dependencies; every parser module imports this package.
package jbp_pkg;

   localparam int FIFO_DEPTH = 4;

   typedef logic [3:0] kind_type;
   localparam kind_type K_NONE   = 4'd0;
   localparam kind_type K_IMM    = 4'd1;
   localparam kind_type K_LOCAL  = 4'd2;
   localparam kind_type K_IINC   = 4'd3;
   localparam kind_type K_CONST  = 4'd4;
   localparam kind_type K_CP     = 4'd5;
   localparam kind_type K_IFACE  = 4'd6;
   localparam kind_type K_INDY   = 4'd7;
   localparam kind_type K_MULTI  = 4'd8;
   localparam kind_type K_BR     = 4'd9;
   localparam kind_type K_WBR    = 4'd10;
   localparam kind_type K_TABLE  = 4'd11;
   localparam kind_type K_LOOKUP = 4'd12;

   typedef logic [1:0] rtype_type;
   localparam rtype_type R_INSTR = 2'd0;
   localparam rtype_type R_ENTRY = 2'd1;
   localparam rtype_type R_ERROR = 2'd2;

   typedef logic [1:0] cause_type;
   localparam cause_type E_WIDE     = 2'd0;
   localparam cause_type E_BOUNDS   = 2'd1;
   localparam cause_type E_TOO_LONG = 2'd2;
   localparam cause_type E_TRUNC    = 2'd3;

   localparam logic [7:0] OP_WIDE   = 8'hC4;
   localparam logic [7:0] OP_SIPUSH = 8'h11;
   localparam logic [7:0] OP_LDC    = 8'h12;

   typedef struct packed {
      rtype_type   record_type;
      logic [15:0] instr_offset;
      logic [7:0]  opcode;
      logic        wide_flag;
      kind_type    opnd_class;
      logic [31:0] value_a;
      logic [31:0] value_b;
      logic [31:0] value_c;
      logic        entry_last;
      cause_type   error_cause;
      logic        code_end;
   } rec_type;

   // Classify an opcode by the shape of its operands.
   function automatic kind_type kind_of(input logic [7:0] op);
      kind_type k;
      k = K_NONE;
      if (op == 8'h10 || op == 8'h11 || op == 8'hBC) k = K_IMM;
      else if ((op >= 8'h15 && op <= 8'h19) || (op >= 8'h36 && op <= 8'h3A) || op == 8'hA9)
         k = K_LOCAL;
      else if (op == 8'h84) k = K_IINC;
      else if (op >= 8'h12 && op <= 8'h14) k = K_CONST;
      else if ((op >= 8'hB2 && op <= 8'hB8) || op == 8'hBB || op == 8'hBD ||
               op == 8'hC0 || op == 8'hC1) k = K_CP;
      else if (op == 8'hB9) k = K_IFACE;
      else if (op == 8'hBA) k = K_INDY;
      else if (op == 8'hC5) k = K_MULTI;
      else if ((op >= 8'h99 && op <= 8'hA8) || op == 8'hC6 || op == 8'hC7) k = K_BR;
      else if (op == 8'hC8 || op == 8'hC9) k = K_WBR;
      else if (op == 8'hAA) k = K_TABLE;
      else if (op == 8'hAB) k = K_LOOKUP;
      return k;
   endfunction

endpackage

/* hdl/jvm_bytecode_instruction_parser.sv */
// Top level of the JVM bytecode parser: decode front end, record queue, output stage.
// Depends on jbp_pkg, jbp_decode, jbp_fifo and jbp_out.
//
// Accepts one bytecode byte every clock cycle while the record queue has room and
// emits at most one record per byte. A record is written into the queue when its
// byte is taken, then passes through the output register to the result stream.
// The queue of QUEUE_DEPTH records (FIFO_DEPTH by default) absorbs result-side
// stalls; input ready drops only when it is full. The method length is written on
// the csr channel, which is always ready; a write takes effect on the next byte.
module jvm_bytecode_instruction_parser
   import jbp_pkg::*;
#(
   parameter int QUEUE_DEPTH = FIFO_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   // tdata: code_byte[7:0]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   // tdata: instr_offset[15:0], opcode[23:16], wide_flag[24], opnd_class[28:25],
   //        value_a[60:29], value_b[92:61], value_c[124:93], error_cause[126:125],
   //        code_end[127]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,
   // tuser: record_type[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   logic [15:0] method_len_ff;
   logic        byte_xfer;
   logic        rec_valid, q_not_full, q_not_empty, q_pop;
   rec_type     rec, head_rec, out_rec;

   // Hold the method length register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) method_len_ff <= 16'hFFFF;
      else if (csr_valid) method_len_ff <= csr_data;
   end

   assign req_tready = q_not_full;
   assign byte_xfer  = req_tvalid && q_not_full;

   jbp_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (byte_xfer),
      .code_byte   (req_tdata),
      .method_len  (method_len_ff),
      .rec_valid   (rec_valid),
      .rec         (rec)
   );

   jbp_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_valid),
      .push_rec  (rec),
      .pop       (q_pop),
      .not_full  (q_not_full),
      .not_empty (q_not_empty),
      .head_rec  (head_rec)
   );

   jbp_out u_out (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_not_empty),
      .head_rec   (head_rec),
      .head_pop   (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rec    (out_rec)
   );

   // Pack the result transfer.
   assign rsp_tdata = {out_rec.code_end, out_rec.error_cause, out_rec.value_c,
                       out_rec.value_b, out_rec.value_a, out_rec.opnd_class,
                       out_rec.wide_flag, out_rec.opcode, out_rec.instr_offset};
   assign rsp_tuser = out_rec.record_type;
   assign rsp_tlast = out_rec.entry_last;

endmodule

/* hdl/jbp_decode.sv */
// Front end: takes one code byte per transfer, tracks offset and parse phase,
// and builds one record whenever a byte completes something. Uses jbp_pkg.
module jbp_decode
   import jbp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_valid,
   input  logic [7:0]  code_byte,
   input  logic [15:0] method_len,
   output logic        rec_valid,
   output rec_type     rec
);

   typedef enum logic [3:0] {
      PH_OPCODE, PH_WIDEOP, PH_F0, PH_F1, PH_F2, PH_PAD, PH_DEFAULT, PH_LOW,
      PH_HIGH, PH_COUNT, PH_TARGET, PH_MATCH, PH_PAIRTGT, PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] offset_ff, offset_in;
   logic [15:0] start_ff, start_in;
   logic [7:0]  op_ff, op_in;
   logic        wide_ff, wide_in;
   kind_type    kind_ff, kind_in;
   logic [31:0] shift_ff, shift_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [31:0] dflt_ff, dflt_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] left_ff, left_in;
   logic        err_ff, err_in;

   logic        last_byte;
   logic [15:0] rem;
   logic [31:0] sh, v, vc;
   logic [2:0]  cnt_inc, w;
   logic [32:0] span;
   logic        emit;
   rtype_type   e_type;
   logic [31:0] e_a, e_b, e_c;
   logic        e_last;
   cause_type   e_cause;
   logic        operand_path;

   // Bytes in operand field idx, zero when the field does not exist.
   function automatic logic [2:0] field_width(input logic [1:0] idx, input kind_type k,
                                              input logic [7:0] op, input logic wd);
      logic [2:0] ww;
      logic [2:0] r;
      ww = wd ? 3'd2 : 3'd1;
      r  = 3'd0;
      case (k)
         K_IMM:   r = (idx == 2'd0) ? ((op == OP_SIPUSH) ? 3'd2 : 3'd1) : 3'd0;
         K_LOCAL: r = (idx == 2'd0) ? ww : 3'd0;
         K_IINC:  r = (idx < 2'd2) ? ww : 3'd0;
         K_CONST: r = (idx == 2'd0) ? ((op == OP_LDC) ? 3'd1 : 3'd2) : 3'd0;
         K_CP:    r = (idx == 2'd0) ? 3'd2 : 3'd0;
         K_IFACE: r = (idx == 2'd0) ? 3'd2 : ((idx < 2'd3) ? 3'd1 : 3'd0);
         K_INDY:  r = (idx < 2'd2) ? 3'd2 : 3'd0;
         K_MULTI: r = (idx == 2'd0) ? 3'd2 : ((idx == 2'd1) ? 3'd1 : 3'd0);
         K_BR:    r = (idx == 2'd0) ? 3'd2 : 3'd0;
         K_WBR:   r = (idx == 2'd0) ? 3'd4 : 3'd0;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   assign last_byte = ((offset_ff + 16'd1) == method_len);
   assign rem       = method_len - offset_ff - 16'd1;
   assign sh        = {shift_ff[23:0], code_byte};
   assign cnt_inc   = cnt_ff + 3'd1;

   // Work out the next parse state and any record for this byte.
   always_comb begin
      phase_in = phase_ff; start_in = start_ff; op_in = op_ff; wide_in = wide_ff;
      kind_in = kind_ff; shift_in = shift_ff; cnt_in = cnt_ff; dflt_in = dflt_ff;
      low_in = low_ff; left_in = left_ff; err_in = err_ff;
      offset_in = offset_ff;
      emit = 1'b0; e_type = R_INSTR; e_a = '0; e_b = '0; e_c = '0;
      e_last = 1'b0; e_cause = E_WIDE;
      v = sh; vc = '0; w = 3'd0; span = '0; operand_path = 1'b0;

      if (byte_valid) begin
         if (!err_ff) begin
            case (phase_ff)
               PH_OPCODE, PH_WIDEOP: begin
                  if (phase_ff == PH_OPCODE) begin
                     start_in = offset_ff; op_in = '0; wide_in = 1'b0; kind_in = K_NONE;
                     shift_in = '0; cnt_in = '0; dflt_in = '0; low_in = '0;
                     left_in = '0; err_in = 1'b0;
                  end
                  if (phase_ff == PH_OPCODE && code_byte == OP_WIDE) begin
                     wide_in  = 1'b1;
                     phase_in = PH_WIDEOP;
                  end else begin
                     op_in   = code_byte;
                     kind_in = kind_of(code_byte);
                     if (wide_in && kind_in != K_LOCAL && kind_in != K_IINC) begin
                        err_in = 1'b1; phase_in = PH_SKIP; emit = 1'b1;
                        e_type = R_ERROR; e_cause = E_WIDE;
                     end else if (kind_in == K_NONE) begin
                        phase_in = PH_OPCODE; emit = 1'b1;
                     end else if (kind_in == K_TABLE || kind_in == K_LOOKUP) begin
                        phase_in = PH_PAD;
                     end else begin
                        phase_in = PH_F0;
                     end
                  end
               end
               PH_PAD: begin
                  // Drop padding; the aligned byte starts the default word.
                  if (offset_ff[1:0] == 2'd0) begin
                     operand_path = 1'b1;
                     phase_in     = PH_DEFAULT;
                  end
               end
               PH_SKIP: ;
               default: operand_path = 1'b1;
            endcase

            if (operand_path) begin
               shift_in = sh;
               cnt_in   = cnt_inc;
               if (phase_ff == PH_F0 || phase_ff == PH_F1 || phase_ff == PH_F2) begin
                  w = field_width(phase_ff == PH_F0 ? 2'd0 : (phase_ff == PH_F1 ? 2'd1 : 2'd2),
                                  kind_ff, op_ff, wide_ff);
                  if (cnt_inc >= w) begin
                     shift_in = '0; cnt_in = '0;
                     if (kind_ff == K_IMM || kind_ff == K_BR || kind_ff == K_WBR ||
                         (kind_ff == K_IINC && phase_ff == PH_F1)) begin
                        case (w)
                           3'd1:    v = {{24{sh[7]}}, sh[7:0]};
                           3'd2:    v = {{16{sh[15]}}, sh[15:0]};
                           default: v = sh;
                        endcase
                     end
                     if (kind_ff == K_BR || kind_ff == K_WBR) v = v + {16'd0, start_ff};
                     if (phase_ff == PH_F0) dflt_in = v;
                     else if (phase_ff == PH_F1 && kind_ff != K_INDY) low_in = v;
                     else vc = v;
                     if (phase_ff != PH_F2 &&
                         field_width(phase_ff == PH_F0 ? 2'd1 : 2'd2, kind_ff, op_ff,
                                     wide_ff) != 3'd0) begin
                        phase_in = (phase_ff == PH_F0) ? PH_F1 : PH_F2;
                     end else begin
                        phase_in = PH_OPCODE; emit = 1'b1;
                        e_a = dflt_in; e_b = low_in; e_c = vc;
                     end
                  end
               end else if (cnt_inc >= 3'd4) begin
                  shift_in = '0; cnt_in = '0;
                  case (phase_ff)
                     PH_PAD, PH_DEFAULT: begin
                        dflt_in  = sh + {16'd0, start_ff};
                        phase_in = (kind_ff == K_TABLE) ? PH_LOW : PH_COUNT;
                     end
                     PH_LOW: begin
                        low_in = sh; phase_in = PH_HIGH;
                     end
                     PH_HIGH: begin
                        span = {1'b0, ~sh[31], sh[30:0]} - {1'b0, ~low_ff[31], low_ff[30:0]}
                               + 33'd1;
                        emit = 1'b1;
                        if ($signed(sh) < $signed(low_ff)) begin
                           err_in = 1'b1; phase_in = PH_SKIP; e_type = R_ERROR;
                           e_cause = E_BOUNDS;
                        end else if (span > {19'd0, rem[15:2]}) begin
                           err_in = 1'b1; phase_in = PH_SKIP; e_type = R_ERROR;
                           e_cause = E_TOO_LONG;
                        end else begin
                           left_in = span[31:0]; phase_in = PH_TARGET;
                           e_a = dflt_ff; e_b = low_ff; e_c = sh;
                        end
                     end
                     PH_COUNT: begin
                        emit = 1'b1;
                        if (sh[31]) begin
                           err_in = 1'b1; phase_in = PH_SKIP; e_type = R_ERROR;
                           e_cause = E_BOUNDS;
                        end else if (sh > {19'd0, rem[15:3]}) begin
                           err_in = 1'b1; phase_in = PH_SKIP; e_type = R_ERROR;
                           e_cause = E_TOO_LONG;
                        end else begin
                           left_in  = sh;
                           phase_in = (sh == 32'd0) ? PH_OPCODE : PH_MATCH;
                           e_a = dflt_ff; e_b = sh;
                        end
                     end
                     PH_TARGET, PH_PAIRTGT: begin
                        left_in = left_ff - 32'd1;
                        emit = 1'b1; e_type = R_ENTRY;
                        e_a = sh + {16'd0, start_ff};
                        e_b = (phase_ff == PH_PAIRTGT) ? low_ff : 32'd0;
                        e_last = (left_in == 32'd0);
                        if (left_in == 32'd0) phase_in = PH_OPCODE;
                        else if (phase_ff == PH_PAIRTGT) phase_in = PH_MATCH;
                     end
                     PH_MATCH: begin
                        low_in = sh; phase_in = PH_PAIRTGT;
                     end
                     default: ;
                  endcase
               end
            end
         end

         // Last byte of the method: flag truncation, then start over.
         if (last_byte) begin
            if (!err_ff && !emit && phase_in != PH_OPCODE) begin
               emit = 1'b1; e_type = R_ERROR; e_cause = E_TRUNC;
               e_a = '0; e_b = '0; e_c = '0; e_last = 1'b0;
            end
            offset_in = '0;
         end else begin
            offset_in = offset_ff + 16'd1;
         end
      end
   end

   // Record seen by the queue; header fields come from the updated state.
   always_comb begin
      rec.record_type  = e_type;
      rec.instr_offset = start_in;
      rec.opcode       = op_in;
      rec.wide_flag    = wide_in;
      rec.opnd_class   = kind_in;
      rec.value_a      = e_a;
      rec.value_b      = e_b;
      rec.value_c      = e_c;
      rec.entry_last   = e_last;
      rec.error_cause  = (e_type == R_ERROR) ? e_cause : E_WIDE;
      rec.code_end     = last_byte;
   end
   assign rec_valid = byte_valid && emit;

   // Hold parse state; clear it after reset and after each method's last byte.
   always_ff @(posedge clock) begin
      if (reset || (byte_valid && last_byte)) begin
         phase_ff <= PH_OPCODE; start_ff <= '0; op_ff <= '0; wide_ff <= 1'b0;
         kind_ff <= K_NONE; shift_ff <= '0; cnt_ff <= '0; dflt_ff <= '0;
         low_ff <= '0; left_ff <= '0; err_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; start_ff <= start_in; op_ff <= op_in; wide_ff <= wide_in;
         kind_ff <= kind_in; shift_ff <= shift_in; cnt_ff <= cnt_in; dflt_ff <= dflt_in;
         low_ff <= low_in; left_ff <= left_in; err_ff <= err_in;
      end
      if (reset) offset_ff <= '0;
      else offset_ff <= offset_in;
   end

endmodule

/* hdl/jbp_fifo.sv */
// Short record queue between the decode front end and the output stage.
// Uses jbp_pkg for the record type, and includes the assertion macro header.
`include "jvm_bytecode_instruction_parser_macros.svh"
module jbp_fifo
   import jbp_pkg::*;
#(
   parameter int DEPTH = FIFO_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rec_type push_rec,
   input  logic    pop,
   output logic    not_full,
   output logic    not_empty,
   output rec_type head_rec
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   rec_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;
   logic          do_push, do_pop;

   assign not_full  = (cnt_ff != FULL_CNT);
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign head_rec  = mem_ff[rd_ff];

   // Store the pushed record.
   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_rec;
   end

   // Advance pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == LAST_PTR) ? '0 : wr_ff + PW'(1);
         if (do_pop)  rd_ff <= (rd_ff == LAST_PTR) ? '0 : rd_ff + PW'(1);
         if (do_push && !do_pop) cnt_ff <= cnt_ff + CW'(1);
         else if (!do_push && do_pop) cnt_ff <= cnt_ff - CW'(1);
      end
   end

   `JBP_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= FULL_CNT)
   `JBP_ASSERT_NEXT(a_cnt_up, clock, reset, do_push && !do_pop, cnt_ff == $past(cnt_ff) + CW'(1))
   `JBP_ASSERT_NEXT(a_cnt_down, clock, reset, do_pop && !do_push, cnt_ff == $past(cnt_ff) - CW'(1))
   `JBP_ASSERT_NOW(a_ptr_gap, clock, reset, cnt_ff == '0, wr_ff == rd_ff)

endmodule

/* hdl/jbp_out.sv */
// Back end: output register that presents queued records on the result stream.
// Uses jbp_pkg for the record type.
module jbp_out
   import jbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  rec_type head_rec,
   output logic    head_pop,
   output logic    out_valid,
   input  logic    out_ready,
   output rec_type out_rec
);

   logic    valid_ff;
   rec_type rec_ff;

   // Refill the register when it is empty or its record is being taken.
   assign head_pop  = head_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_rec   = rec_ff;

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (!valid_ff || out_ready) valid_ff <= head_valid;
      if (head_pop) rec_ff <= head_rec;
   end

endmodule
